### src/iir5_pkg.sv
// Shared constants, types and register codes for the fifth-order IIR filter.
// No dependencies; every other file of the filter refers to this package.
package iir5_pkg;

    localparam int TAPS           = 6;
    localparam int SAMPLE_WIDTH   = 32;
    localparam int COEF_FRAC_BITS = 26;

    localparam int COEF_W      = 32;
    localparam int COEF_SLOTS  = 6;
    localparam int TAP_W       = $clog2(COEF_SLOTS);
    localparam int HDEPTH      = TAPS - 1;
    localparam int HIST_IDX_W  = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int NUM_STEPS   = 2 * TAPS - 1;
    localparam int STEP_W      = $clog2(NUM_STEPS);
    localparam int PROD_W      = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W       = PROD_W + 4;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FEED_FWD_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_FWD_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_FWD_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_12 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_34 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_5  = 3'd5;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX    = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = ~SAT_MAX;

    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]        acc_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic negate;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_ROUND = 4'b1000
    } state_t;

endpackage

### src/iir5_in_if.sv
// Request channel that carries input samples into the filter.
// Depends on iir5_pkg for the sample width.
interface iir5_in_if;
    logic                  valid;
    logic                  ready;
    iir5_pkg::sample_t     sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

### src/iir5_out_if.sv
// Request channel that carries filtered samples out of the filter.
// Depends on iir5_pkg for the sample width.
interface iir5_out_if;
    logic                  valid;
    logic                  ready;
    iir5_pkg::sample_t     sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

### src/iir5_coef_regs.sv
// Coefficient register file: unpacks the packed configuration writes into b and a terms.
// Depends on iir5_pkg.
module iir5_coef_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [iir5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iir5_pkg::CFG_W-1:0]     cfg_data,
    output iir5_pkg::coef_t                coef_b [iir5_pkg::COEF_SLOTS],
    output iir5_pkg::coef_t                coef_a [1:iir5_pkg::COEF_SLOTS-1]
);

    iir5_pkg::coef_t coef_b_reg [iir5_pkg::COEF_SLOTS];
    iir5_pkg::coef_t coef_a_reg [1:iir5_pkg::COEF_SLOTS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iir5_pkg::COEF_SLOTS; i++)
            begin
                coef_b_reg[i] <= '0;
            end
            for (int i = 1; i < iir5_pkg::COEF_SLOTS; i++)
            begin
                coef_a_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                iir5_pkg::REG_FEED_FWD_01:
                begin
                    coef_b_reg[0] <= cfg_data[31:0];
                    coef_b_reg[1] <= cfg_data[63:32];
                end
                iir5_pkg::REG_FEED_FWD_23:
                begin
                    coef_b_reg[2] <= cfg_data[31:0];
                    coef_b_reg[3] <= cfg_data[63:32];
                end
                iir5_pkg::REG_FEED_FWD_45:
                begin
                    coef_b_reg[4] <= cfg_data[31:0];
                    coef_b_reg[5] <= cfg_data[63:32];
                end
                iir5_pkg::REG_FEEDBACK_12:
                begin
                    coef_a_reg[1] <= cfg_data[31:0];
                    coef_a_reg[2] <= cfg_data[63:32];
                end
                iir5_pkg::REG_FEEDBACK_34:
                begin
                    coef_a_reg[3] <= cfg_data[31:0];
                    coef_a_reg[4] <= cfg_data[63:32];
                end
                iir5_pkg::REG_FEEDBACK_5:
                begin
                    coef_a_reg[5] <= cfg_data[31:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign coef_b = coef_b_reg;
    assign coef_a = coef_a_reg;

endmodule

### src/iir5_mac.sv
// Shared multiply-accumulate unit: one registered signed product, then an exact accumulator.
// Depends on iir5_pkg.
module iir5_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  iir5_pkg::mac_ctrl_t ctrl,
    input  iir5_pkg::sample_t   sample,
    input  iir5_pkg::coef_t     coef,
    output iir5_pkg::acc_t      acc
);

    logic signed [iir5_pkg::PROD_W-1:0] prod_reg;
    logic                               prod_valid_reg;
    logic                               prod_neg_reg;
    iir5_pkg::acc_t                     acc_reg;
    iir5_pkg::acc_t                     acc_next;
    iir5_pkg::acc_t                     prod_ext;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= iir5_pkg::PROD_W'(sample) * iir5_pkg::PROD_W'(coef);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_neg_reg   <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mul_en;
            prod_neg_reg   <= ctrl.negate;
            acc_reg        <= acc_next;
        end
    end

    assign prod_ext = {{(iir5_pkg::ACC_W - iir5_pkg::PROD_W){prod_reg[iir5_pkg::PROD_W-1]}},
                       prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = prod_neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    assign acc = acc_reg;

endmodule

### src/iir_fifth_order_filter_core.sv
// Fifth-order direct form I IIR filter with one shared multiply-accumulate unit.
// An accepted input request passes through ST_MAC, ST_DRAIN and ST_ROUND before the output request is valid.
// The 11 products share the single multiplier, so a new sample is accepted only back in ST_IDLE.
// The output register lets the next sample enter while a result waits to be taken.
// Reset (asynchronous, active low) clears the histories, coefficients and all control state.
module iir_fifth_order_filter_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [iir5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iir5_pkg::CFG_W-1:0]     cfg_data,
    iir5_in_if.sink                        x_stream,
    iir5_out_if.source                     y_stream
);

    iir5_pkg::coef_t coef_b [iir5_pkg::COEF_SLOTS];
    iir5_pkg::coef_t coef_a [1:iir5_pkg::COEF_SLOTS-1];

    iir5_pkg::state_t  state_reg;
    iir5_pkg::state_t  state_next;
    logic [iir5_pkg::STEP_W-1:0] step_reg;
    logic [iir5_pkg::STEP_W-1:0] step_next;

    iir5_pkg::sample_t x_reg;
    iir5_pkg::sample_t x_hist_reg [iir5_pkg::HDEPTH];
    iir5_pkg::sample_t y_hist_reg [iir5_pkg::HDEPTH];
    logic              y_valid_reg;
    iir5_pkg::sample_t y_data_reg;

    iir5_pkg::mac_ctrl_t mac_ctrl;
    iir5_pkg::sample_t   mac_sample;
    iir5_pkg::coef_t     mac_coef;
    iir5_pkg::acc_t      acc;
    iir5_pkg::acc_t      acc_rnd;
    iir5_pkg::acc_t      acc_shift;
    iir5_pkg::sample_t   y_sat;

    logic [iir5_pkg::STEP_W-1:0]     step_inc;
    logic [iir5_pkg::TAP_W-1:0]      tap;
    logic [iir5_pkg::HIST_IDX_W-1:0] hidx;
    logic                            in_fire;
    logic                            out_free;
    logic                            finish;

    iir5_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef_b    (coef_b),
        .coef_a    (coef_a)
    );

    iir5_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (mac_sample),
        .coef   (mac_coef),
        .acc    (acc)
    );

    assign x_stream.ready = (state_reg == iir5_pkg::ST_IDLE);
    assign in_fire        = x_stream.valid && x_stream.ready;
    assign out_free       = !y_valid_reg || y_stream.ready;
    assign finish         = (state_reg == iir5_pkg::ST_ROUND) && out_free;

    // Step 0 is b0*x; odd steps take b(i)*x[n-i], even steps take -a(i)*y[n-i].
    assign step_inc = step_reg + iir5_pkg::STEP_W'(1);
    assign tap      = iir5_pkg::TAP_W'(step_inc >> 1);
    assign hidx     = iir5_pkg::HIST_IDX_W'(tap - iir5_pkg::TAP_W'(1));

    always_comb
    begin
        mac_ctrl.clear  = in_fire;
        mac_ctrl.mul_en = (state_reg == iir5_pkg::ST_MAC);
        mac_ctrl.negate = 1'b0;
        mac_sample      = x_reg;
        mac_coef        = coef_b[0];
        if (step_reg != '0)
        begin
            if (step_reg[0])
            begin
                mac_sample = x_hist_reg[hidx];
                mac_coef   = coef_b[tap];
            end
            else
            begin
                mac_sample      = y_hist_reg[hidx];
                mac_coef        = coef_a[tap];
                mac_ctrl.negate = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            iir5_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = iir5_pkg::ST_MAC;
                    step_next  = '0;
                end
            end
            iir5_pkg::ST_MAC:
            begin
                if (step_reg == iir5_pkg::STEP_W'(iir5_pkg::NUM_STEPS - 1))
                begin
                    state_next = iir5_pkg::ST_DRAIN;
                end
                else
                begin
                    step_next = step_inc;
                end
            end
            iir5_pkg::ST_DRAIN:
            begin
                state_next = iir5_pkg::ST_ROUND;
            end
            iir5_pkg::ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = iir5_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iir5_pkg::ST_IDLE;
            end
        endcase
    end

    // Round to nearest with ties upward, then saturate to the sample range.
    assign acc_rnd   = acc + iir5_pkg::ROUND_HALF;
    assign acc_shift = acc_rnd >>> iir5_pkg::COEF_FRAC_BITS;

    always_comb
    begin
        if (acc_shift > iir5_pkg::SAT_MAX)
        begin
            y_sat = iir5_pkg::SAT_MAX[iir5_pkg::SAMPLE_WIDTH-1:0];
        end
        else if (acc_shift < iir5_pkg::SAT_MIN)
        begin
            y_sat = iir5_pkg::SAT_MIN[iir5_pkg::SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_sat = acc_shift[iir5_pkg::SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= x_stream.sample_in;
        end
        if (finish)
        begin
            y_data_reg <= y_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iir5_pkg::ST_IDLE;
            step_reg    <= '0;
            y_valid_reg <= 1'b0;
            for (int i = 0; i < iir5_pkg::HDEPTH; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (finish)
            begin
                y_valid_reg   <= 1'b1;
                x_hist_reg[0] <= x_reg;
                y_hist_reg[0] <= y_sat;
                for (int i = 1; i < iir5_pkg::HDEPTH; i++)
                begin
                    x_hist_reg[i] <= x_hist_reg[i-1];
                    y_hist_reg[i] <= y_hist_reg[i-1];
                end
            end
            else if (y_stream.ready)
            begin
                y_valid_reg <= 1'b0;
            end
        end
    end

    assign y_stream.valid      = y_valid_reg;
    assign y_stream.sample_out = y_data_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        x_stream.valid && x_stream.ready |=> state_reg == iir5_pkg::ST_MAC && step_reg == '0)
        else $error("accepted request did not start the product sequence");

    a_drain_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == iir5_pkg::ST_DRAIN |->
            $past(state_reg) == iir5_pkg::ST_MAC &&
            $past(step_reg) == iir5_pkg::STEP_W'(iir5_pkg::NUM_STEPS - 1))
        else $error("drain entered before all products were issued");

    a_result_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(y_valid_reg) |-> $past(state_reg) == iir5_pkg::ST_ROUND)
        else $error("output request raised outside the rounding step");
`endif

endmodule

### tb/iir5_filter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the fifth-order IIR filter: it follows the configuration port and both
// request channels, predicts every filtered sample and compares it when it arrives.
// Depends on iir5_pkg and on the iir5_in_if and iir5_out_if interfaces.
module iir5_filter_checker
    import iir5_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    iir5_in_if                   x_mon,
    iir5_out_if                  y_mon,
    output int                   fail_count,
    output int                   pending
);

    localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [127:0] OUT_MAX  = (128'sd1 <<< (SAMPLE_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] OUT_MIN  = -(128'sd1 <<< (SAMPLE_WIDTH - 1));

    coef_t   b_coef [COEF_SLOTS];
    coef_t   a_coef [COEF_SLOTS];
    sample_t x_hist [HDEPTH];
    sample_t y_hist [HDEPTH];
    int      ring_pos;
    sample_t expected_out_q [$];
    sample_t want;

    // The sum of all products is exact, so the only losses are the final rounding and saturation.
    function automatic sample_t filter_next(input sample_t x);
        logic signed [127:0] sum;
        logic signed [127:0] scaled;
        sample_t             y;
        int                  slot;
        sum = 128'(x) * 128'(b_coef[0]);
        for (int i = 1; i < TAPS; i++) begin
            slot = (ring_pos + HDEPTH - i) % HDEPTH;
            sum = sum + 128'(x_hist[slot]) * 128'(b_coef[i])
                      - 128'(y_hist[slot]) * 128'(a_coef[i]);
        end
        scaled = (sum + HALF_LSB) >>> COEF_FRAC_BITS;
        if (scaled > OUT_MAX)
            y = sample_t'(OUT_MAX);
        else if (scaled < OUT_MIN)
            y = sample_t'(OUT_MIN);
        else
            y = sample_t'(scaled);
        x_hist[ring_pos] = x;
        y_hist[ring_pos] = y;
        ring_pos = (ring_pos + 1) % HDEPTH;
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < COEF_SLOTS; k++)
            begin
                b_coef[k] = '0;
                a_coef[k] = '0;
            end
            for (int k = 0; k < HDEPTH; k++)
            begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
            ring_pos = 0;
            expected_out_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FEED_FWD_01:
                    begin
                        b_coef[0] = cfg_data[31:0];
                        b_coef[1] = cfg_data[63:32];
                    end
                    REG_FEED_FWD_23:
                    begin
                        b_coef[2] = cfg_data[31:0];
                        b_coef[3] = cfg_data[63:32];
                    end
                    REG_FEED_FWD_45:
                    begin
                        b_coef[4] = cfg_data[31:0];
                        b_coef[5] = cfg_data[63:32];
                    end
                    REG_FEEDBACK_12:
                    begin
                        a_coef[1] = cfg_data[31:0];
                        a_coef[2] = cfg_data[63:32];
                    end
                    REG_FEEDBACK_34:
                    begin
                        a_coef[3] = cfg_data[31:0];
                        a_coef[4] = cfg_data[63:32];
                    end
                    REG_FEEDBACK_5:
                    begin
                        a_coef[5] = cfg_data[31:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (y_mon.valid && y_mon.ready)
            begin
                if (expected_out_q.size() == 0)
                begin
                    $display("%0t: unexpected output request, sample_out %h",
                             $time, y_mon.sample_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_out_q.pop_front();
                    if (y_mon.sample_out !== want)
                    begin
                        $display("%0t: sample_out mismatch, expected %h actual %h",
                                 $time, want, y_mon.sample_out);
                        fail_count++;
                    end
                end
            end
            if (x_mon.valid && x_mon.ready)
                expected_out_q.push_back(filter_next(x_mon.sample_in));
            pending = expected_out_q.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the filter testbench: clock, reset, coefficient loads and sample requests.
// Depends on iir5_pkg, both channel interfaces, the filter core and iir5_filter_checker.
module testbench;
    import iir5_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam coef_t   Q_ONE     = 32'sh0400_0000;
    localparam coef_t   Q_HALF    = 32'sh0200_0000;
    localparam coef_t   Q_NEG_ONE = -32'sh0400_0000;
    localparam coef_t   COEF_MAX  = 32'sh7FFF_FFFF;
    localparam coef_t   COEF_MIN  = 32'sh8000_0000;
    localparam sample_t S_MAX     = 32'sh7FFF_FFFF;
    localparam sample_t S_MIN     = 32'sh8000_0000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 steady;
    int                   fail_count;
    int                   pending;

    iir5_in_if  x_ch ();
    iir5_out_if y_ch ();

    iir_fifth_order_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .x_stream  (x_ch),
        .y_stream  (y_ch)
    );

    iir5_filter_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .x_mon      (x_ch),
        .y_mon      (y_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge clk)
        y_ch.ready = steady || ($urandom_range(0, 99) >= 6);

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // The upper half of feedback_5 and the unmapped indexes get random data that must be ignored.
    task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                              input coef_t b3, input coef_t b4, input coef_t b5,
                              input coef_t a1, input coef_t a2, input coef_t a3,
                              input coef_t a4, input coef_t a5);
        write_reg(REG_FEED_FWD_01, {b1, b0});
        write_reg(REG_FEED_FWD_23, {b3, b2});
        write_reg(REG_FEED_FWD_45, {b5, b4});
        write_reg(REG_FEEDBACK_12, {a2, a1});
        write_reg(REG_FEEDBACK_34, {a4, a3});
        write_reg(REG_FEEDBACK_5, {32'($urandom), a5});
        write_reg(REG_SPARE_6, {32'($urandom), 32'($urandom)});
        write_reg(REG_SPARE_7, {32'($urandom), 32'($urandom)});
    endtask

    task automatic send_sample(input sample_t value);
        logic taken;
        while (!steady && $urandom_range(0, 99) < 6)
        begin
            x_ch.valid = 1'b0;
            @(negedge clk);
        end
        x_ch.valid = 1'b1;
        x_ch.sample_in = value;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = x_ch.ready;
            @(negedge clk);
        end
    endtask

    task automatic settle();
        x_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5, 6, 7: return sample_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            8:          return $urandom_range(0, 1) ? S_MAX : S_MIN;
            default:    return '0;
        endcase
    endfunction

    function automatic coef_t rand_coef();
        case ($urandom_range(0, 3))
            0:       return coef_t'($urandom);
            default: return coef_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_sample(rand_sample());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        x_ch.valid = 1'b0;
        x_ch.sample_in = '0;
        y_ch.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // With the coefficients still at their reset value every output is zero.
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(sample_t'($urandom));
        settle();

        load_coefs(Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(0);
        send_sample(1);
        send_sample(-1);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(32'sh0001_0000);
        send_sample(32'shAAAA_AAAA);
        send_sample(32'sh5555_5555);
        settle();

        // Halving odd values lands exactly on ties, which round toward plus infinity.
        load_coefs(Q_HALF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(1);
        send_sample(-1);
        send_sample(3);
        send_sample(-3);
        settle();

        load_coefs(COEF_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(S_MAX);
        send_sample(S_MIN);
        settle();
        load_coefs(COEF_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(S_MIN);
        settle();

        // An integrator saturates, and the clipped value is what feeds back.
        load_coefs(Q_ONE, 0, 0, 0, 0, 0, Q_NEG_ONE, 0, 0, 0, 0);
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MIN);
        settle();

        // Unity-gain low-pass with all five poles at one half.
        load_coefs(32'sd65536, 32'sd327680, 32'sd655360, 32'sd655360, 32'sd327680,
                   32'sd65536, -32'sd167772160, 32'sd167772160, -32'sd83886080,
                   32'sd20971520, -32'sd2097152);
        steady = 1'b1;
        run_random(150);
        steady = 1'b0;
        settle();
        run_random(50);
        settle();

        repeat (7)
        begin
            load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef());
            run_random(50);
            settle();
        end

        load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
                   COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
        run_random(25);
        settle();
        load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX,
                   COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        run_random(25);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
